>>> rtl/core/bcdcsu_pkg.sv
// Package: operation codes, widths and stage types for the BCD convert and subtract unit
`timescale 1ns / 1ps
`default_nettype none

package bcdcsu_pkg;

    typedef enum logic [1:0] {
        OP_BCD2BIN = 2'd0,
        OP_BIN2BCD = 2'd1,
        OP_BCDSUB  = 2'd2,
        OP_RSVD    = 2'd3
    } op_t;

    localparam int OP_W      = 2;
    localparam int WORD_W    = 32;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int DD_STEPS  = 4;
    localparam int DD_STAGES = WORD_W / DD_STEPS;
    localparam int IN_W      = 64;
    localparam int OUT_W     = 40;

    typedef struct packed {
        logic [WORD_W-1:0] bin;
        logic [BCD_W-1:0]  bcd;
    } dd_t;

    typedef struct packed {
        logic              conv;
        logic              und;
        logic [WORD_W-1:0] byp;
    } side_t;

endpackage

`default_nettype wire

>>> rtl/core/bcd32_convert_and_subtract_unit.sv
// Top level: pipelined 8-digit packed BCD convert and subtract unit
// Throughput: one transfer per cycle; the whole pipeline holds while a result is stalled.
// Binary to BCD runs as a shift-and-add-3 chain of 8 stages, 4 bits per stage.
// Reset: asynchronous, active low; clears all stage valid flags, pipeline comes up empty.
`timescale 1ns / 1ps
`default_nettype none

module bcd32_convert_and_subtract_unit
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // operand_a[31:0], operand_b[63:32]
    input  wire logic [bcdcsu_pkg::IN_W-1:0] s_tdata,
    // op[1:0]
    input  wire logic [bcdcsu_pkg::OP_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // result[31:0], underflow[32], overflow[33], zero pad [39:34]
    output logic [bcdcsu_pkg::OUT_W-1:0]   m_tdata
);

    localparam int W  = bcdcsu_pkg::WORD_W;
    localparam int NS = bcdcsu_pkg::DD_STAGES;

    function automatic logic [14:0] bcd4_to_bin(input logic [15:0] w);
        return 15'(w[3:0]) + 15'(w[7:4]) * 15'd10 + 15'(w[11:8]) * 15'd100
             + 15'(w[15:12]) * 15'd1000;
    endfunction

    function automatic bcdcsu_pkg::dd_t dd_step(input bcdcsu_pkg::dd_t d);
        bcdcsu_pkg::dd_t r;
        r = d;
        for (int s = 0; s < bcdcsu_pkg::DD_STEPS; s++)
        begin
            for (int g = 0; g < bcdcsu_pkg::DIGITS; g++)
            begin
                if (r.bcd[4*g +: 4] >= 4'd5)
                begin
                    r.bcd[4*g +: 4] = r.bcd[4*g +: 4] + 4'd3;
                end
            end
            r.bcd = {r.bcd[bcdcsu_pkg::BCD_W-2:0], r.bin[W-1]};
            r.bin = {r.bin[W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic adv;

    logic              v0_reg, v1_reg, v2_reg;
    logic [1:0]        op0_reg, op1_reg, op2_reg;
    logic [W-1:0]      a0_reg, b0_reg, a1_reg, a2_reg;
    logic [14:0]       lo_a_reg, hi_a_reg, lo_b_reg, hi_b_reg;
    logic [W-1:0]      va_reg, vb_reg;

    logic              dv_reg [0:NS];
    bcdcsu_pkg::dd_t   dd_reg [0:NS];
    bcdcsu_pkg::side_t sd_reg [0:NS];

    logic                         out_vld_reg;
    logic [bcdcsu_pkg::OUT_W-1:0] out_data_reg;

    bcdcsu_pkg::dd_t   dd_next;
    bcdcsu_pkg::side_t sd_next;
    logic [9:0]        top_q;
    logic [W-1:0]      res_next;
    logic              ovf_next;

    assign adv      = !(out_vld_reg && !m_tready);
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        dd_next.bin = '0;
        dd_next.bcd = '0;
        sd_next.conv = 1'b0;
        sd_next.und  = 1'b0;
        sd_next.byp  = '0;
        unique case (bcdcsu_pkg::op_t'(op2_reg))
            bcdcsu_pkg::OP_BCD2BIN:
            begin
                sd_next.byp = va_reg;
            end
            bcdcsu_pkg::OP_BIN2BCD:
            begin
                sd_next.conv = 1'b1;
                dd_next.bin  = a2_reg;
            end
            bcdcsu_pkg::OP_BCDSUB:
            begin
                if (va_reg < vb_reg)
                begin
                    sd_next.und = 1'b1;
                    sd_next.byp = '1;
                end
                else
                begin
                    sd_next.conv = 1'b1;
                    dd_next.bin  = va_reg - vb_reg;
                end
            end
            default:
            begin
                sd_next.byp = '0;
            end
        endcase
    end

    always_comb
    begin
        top_q = 10'(dd_reg[NS].bcd[39:36]) * 10'd100 + 10'(dd_reg[NS].bcd[35:32]) * 10'd10
              + 10'(dd_reg[NS].bcd[31:28]);
        if (sd_reg[NS].conv)
        begin
            res_next = {top_q[3:0], dd_reg[NS].bcd[27:0]};
            ovf_next = |dd_reg[NS].bcd[39:32];
        end
        else
        begin
            res_next = sd_reg[NS].byp;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i <= NS; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v0_reg    <= s_tvalid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            for (int i = 0; i < NS; i++)
            begin
                dv_reg[i+1] <= dv_reg[i];
            end
            out_vld_reg <= dv_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op0_reg  <= s_tuser;
            a0_reg   <= s_tdata[31:0];
            b0_reg   <= s_tdata[63:32];

            op1_reg  <= op0_reg;
            a1_reg   <= a0_reg;
            lo_a_reg <= bcd4_to_bin(a0_reg[15:0]);
            hi_a_reg <= bcd4_to_bin(a0_reg[31:16]);
            lo_b_reg <= bcd4_to_bin(b0_reg[15:0]);
            hi_b_reg <= bcd4_to_bin(b0_reg[31:16]);

            op2_reg  <= op1_reg;
            a2_reg   <= a1_reg;
            va_reg   <= W'(hi_a_reg) * 32'd10000 + W'(lo_a_reg);
            vb_reg   <= W'(hi_b_reg) * 32'd10000 + W'(lo_b_reg);

            dd_reg[0] <= dd_next;
            sd_reg[0] <= sd_next;
            for (int i = 0; i < NS; i++)
            begin
                dd_reg[i+1] <= dd_step(dd_reg[i]);
                sd_reg[i+1] <= sd_reg[i];
            end

            out_data_reg <= {6'd0, ovf_next, sd_reg[NS].und, res_next};
        end
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for the packed BCD convert and subtract unit: directed, back-pressure, sender-pause and random checks
`timescale 1ns / 1ps

module tb;

    localparam int unsigned RUN_LIMIT  = 400000;
    localparam int          MAX_SHOWN  = 10;

    typedef struct {
        bit [31:0] result;
        bit        underflow;
        bit        overflow;
    } conversion_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [bcdcsu_pkg::IN_W-1:0]   s_tdata;
    logic [bcdcsu_pkg::OP_W-1:0]   s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [bcdcsu_pkg::OUT_W-1:0]  m_tdata;

    conversion_t       expected_results[$];
    int                fail_count;
    int unsigned       cycle_count;
    bit                idle_en;
    int                hold_cycles;

    bcd32_convert_and_subtract_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit [31:0] bcd_word_value(input bit [31:0] word);
        bit [31:0] acc;
        bit [31:0] weight;
        acc    = 32'd0;
        weight = 32'd1;
        for (int k = 0; k < 8; k++)
        begin
            acc    = acc + 32'(word[4*k +: 4]) * weight;
            weight = weight * 32'd10;
        end
        return acc;
    endfunction

    function automatic bit [31:0] pack_decimal(input bit [31:0] value, output bit ovf);
        bit [31:0] low;
        bit [31:0] top;
        bit [31:0] digit;
        bit [31:0] acc;
        low = value % 32'd10000000;
        top = value / 32'd10000000;
        acc = {top[3:0], 28'h0};
        for (int k = 0; k < 7; k++)
        begin
            digit            = low % 32'd10;
            acc[4*k +: 4]    = digit[3:0];
            low              = low / 32'd10;
        end
        ovf = (value > 32'd99999999);
        return acc;
    endfunction

    function automatic conversion_t predict_conversion(input bcdcsu_pkg::op_t op,
                                                       input bit [31:0] a,
                                                       input bit [31:0] b);
        conversion_t r;
        bit [31:0]   va;
        bit [31:0]   vb;
        bit          ovf;
        r.result    = 32'd0;
        r.underflow = 1'b0;
        r.overflow  = 1'b0;
        case (op)
            bcdcsu_pkg::OP_BCD2BIN: r.result = bcd_word_value(a);
            bcdcsu_pkg::OP_BIN2BCD:
            begin
                r.result   = pack_decimal(a, ovf);
                r.overflow = ovf;
            end
            bcdcsu_pkg::OP_BCDSUB:
            begin
                va = bcd_word_value(a);
                vb = bcd_word_value(b);
                if (va < vb)
                begin
                    r.result    = 32'hffffffff;
                    r.underflow = 1'b1;
                end
                else
                begin
                    r.result   = pack_decimal(va - vb, ovf);
                    r.overflow = ovf;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bit [31:0] random_bcd();
        bit [31:0] w;
        for (int k = 0; k < 8; k++)
            w[4*k +: 4] = 4'($urandom_range(0, 9));
        return w;
    endfunction

    task automatic send_item(input bcdcsu_pkg::op_t op, input bit [31:0] a,
                             input bit [31:0] b);
        @(negedge clk);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(predict_conversion(op, a, b));
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(bcdcsu_pkg::OP_BCD2BIN, 32'h00000000, 32'hffffffff);
        send_item(bcdcsu_pkg::OP_BCD2BIN, 32'h99999999, 32'h00000000);
        send_item(bcdcsu_pkg::OP_BCD2BIN, 32'hffffffff, 32'h12345678);
        send_item(bcdcsu_pkg::OP_BCD2BIN, 32'ha0b0c0d0, 32'h00000000);
        send_item(bcdcsu_pkg::OP_BCD2BIN, 32'h12345678, 32'h00000000);
        send_item(bcdcsu_pkg::OP_BIN2BCD, 32'd0, 32'hffffffff);
        send_item(bcdcsu_pkg::OP_BIN2BCD, 32'd99999999, 32'h00000000);
        send_item(bcdcsu_pkg::OP_BIN2BCD, 32'd100000000, 32'h00000000);
        send_item(bcdcsu_pkg::OP_BIN2BCD, 32'd159999999, 32'h00000000);
        send_item(bcdcsu_pkg::OP_BIN2BCD, 32'd160000000, 32'h00000000);
        send_item(bcdcsu_pkg::OP_BIN2BCD, 32'hffffffff, 32'h55555555);
        send_item(bcdcsu_pkg::OP_BCDSUB, 32'h12345678, 32'h12345678);
        send_item(bcdcsu_pkg::OP_BCDSUB, 32'h00000000, 32'h00000001);
        send_item(bcdcsu_pkg::OP_BCDSUB, 32'h00000000, 32'hffffffff);
        send_item(bcdcsu_pkg::OP_BCDSUB, 32'h99999999, 32'h00000000);
        send_item(bcdcsu_pkg::OP_BCDSUB, 32'hffffffff, 32'h00000000);
        send_item(bcdcsu_pkg::OP_BCDSUB, 32'h50000000, 32'h00000001);
        send_item(bcdcsu_pkg::OP_BCDSUB, 32'hf0000000, 32'h0000000f);
        send_item(bcdcsu_pkg::OP_RSVD, 32'hffffffff, 32'hffffffff);
        send_item(bcdcsu_pkg::OP_RSVD, 32'h00000000, 32'h00000000);
        wait_results_done();
    endtask

    task automatic send_random_item();
        bcdcsu_pkg::op_t op;
        bit [31:0]       a;
        bit [31:0]       b;
        bit [31:0]       t;
        int              sel;
        sel = $urandom_range(0, 19);
        a   = $urandom;
        b   = $urandom;
        if (sel < 6)
        begin
            op = bcdcsu_pkg::OP_BCD2BIN;
            if ($urandom_range(0, 2) != 0)
                a = random_bcd();
        end
        else if (sel < 12)
        begin
            op = bcdcsu_pkg::OP_BIN2BCD;
            case ($urandom_range(0, 3))
                0, 1: a = $urandom_range(0, 99999999);
                2:    a = $urandom_range(99999990, 100000010);
                default: ;
            endcase
        end
        else if (sel < 19)
        begin
            op = bcdcsu_pkg::OP_BCDSUB;
            if ($urandom_range(0, 3) != 0)
            begin
                a = random_bcd();
                b = random_bcd();
            end
            if ($urandom_range(0, 2) != 0 && bcd_word_value(a) < bcd_word_value(b))
            begin
                t = a;
                a = b;
                b = t;
            end
        end
        else
            op = bcdcsu_pkg::OP_RSVD;
        send_item(op, a, b);
    endtask

    task automatic test_backpressure();
        send_random_item();
        hold_cycles = 300;
        repeat (80) send_random_item();
        wait_results_done();
    endtask

    task automatic test_sender_pause();
        repeat (30) send_random_item();
        wait_results_done();
        repeat (30) send_random_item();
        wait_results_done();
    endtask

    task automatic test_random();
        for (int i = 0; i < 1400; i++)
        begin
            if (i == 1120)
                idle_en = 1'b0;
            send_random_item();
        end
        wait_results_done();
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                m_tready <= 1'b0;
            else if (hold_cycles > 0)
            begin
                m_tready    <= 1'b0;
                hold_cycles  = hold_cycles - 1;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        conversion_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("unexpected transfer: data %h", m_tdata);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tdata[31:0] !== exp_r.result || m_tdata[32] !== exp_r.underflow
                    || m_tdata[33] !== exp_r.overflow)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("mismatch: result %h/%h underflow %b/%b overflow %b/%b",
                                 exp_r.result, m_tdata[31:0], exp_r.underflow, m_tdata[32],
                                 exp_r.overflow, m_tdata[33]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("bcd32_convert_and_subtract_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        fail_count  = 0;
        cycle_count = 0;
        idle_en     = 1'b1;
        hold_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_sender_pause();
        test_random();

        repeat (30) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("bcd32_convert_and_subtract_unit verification clean");
        else
            $display("bcd32_convert_and_subtract_unit verification failed");
        $finish;
    end

endmodule

>>> bcd32_convert_and_subtract_unit.f
rtl/core/bcdcsu_pkg.sv
rtl/core/bcd32_convert_and_subtract_unit.sv
tb/tb.sv
